// ===== hw/rtl/cfs_pkg.sv =====
// ============================================================================
// cfs_pkg
// Shared types, field widths and helpers for the call-frame stack unit.
// ============================================================================
package cfs_pkg;

    // Field widths of the request and response channels
    localparam int OP_W    = 2;
    localparam int RA_W    = 32;
    localparam int VC_W    = 11;
    localparam int DEPTH_W = 10;
    localparam int IDX_W   = 10;
    localparam int DATA_W  = 64;
    localparam int NB_W    = 4;
    localparam int FC_W    = 10;

    // Internal bookkeeping widths
    localparam int UB_W    = 14;            // used bytes
    localparam int CAP_W   = 14;            // capacity register
    localparam int TOP_W   = UB_W - 3;      // used bytes in words
    localparam int CNT_W   = VC_W + 1;      // words of one frame
    localparam int FSZ_W   = CNT_W + 3;     // bytes of one frame

    // Header word layout
    localparam int HDR_VC_LSB = 32;

    // Parameter defaults
    localparam int STORE_WORDS_DEF  = 1024;
    localparam int HEADER_BYTES_DEF = 16;

    // Limits and reset values
    localparam logic [CAP_W-1:0] CAP_RESET  = 14'd8192;
    localparam logic [FC_W-1:0]  FRAMES_MAX = 10'd1023;

    // APB register file
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_CAPACITY = 1'b0;   // register index, paddr[2]

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_POP_HDR,
        ST_POP_RET,
        ST_WALK,
        ST_ACCESS,
        ST_DONE
    } state_t;

    // Mask of the low nb bytes, all ones from eight bytes up
    function automatic logic [DATA_W-1:0] byte_mask(input logic [NB_W-1:0] nb);
        logic [DATA_W-1:0] m;
        m = '1;
        if (nb < NB_W'(8))
        begin
            m = ~({DATA_W{1'b1}} << {nb[2:0], 3'b000});
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/cfs_req_if.sv =====
// ============================================================================
// cfs_req_if
// Request channel of the call-frame stack: valid/ready plus operation fields.
// ============================================================================
interface cfs_req_if;
    logic                          valid;
    logic                          ready;
    cfs_pkg::op_t                  op;
    logic [cfs_pkg::RA_W-1:0]      return_address;
    logic [cfs_pkg::VC_W-1:0]      var_count;
    logic [cfs_pkg::DEPTH_W-1:0]   frame_depth;
    logic [cfs_pkg::IDX_W-1:0]     var_index;
    logic [cfs_pkg::DATA_W-1:0]    write_value;
    logic [cfs_pkg::NB_W-1:0]      byte_count;

    modport source (
        output valid, op, return_address, var_count, frame_depth, var_index,
               write_value, byte_count,
        input  ready
    );

    modport sink (
        input  valid, op, return_address, var_count, frame_depth, var_index,
               write_value, byte_count,
        output ready
    );
endinterface

// ===== hw/rtl/cfs_rsp_if.sv =====
// ============================================================================
// cfs_rsp_if
// Response channel of the call-frame stack: valid/ready plus result fields.
// ============================================================================
interface cfs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [cfs_pkg::DATA_W-1:0]    read_value;
    logic [cfs_pkg::RA_W-1:0]      top_return_address;
    logic [cfs_pkg::FC_W-1:0]      frame_count;

    modport source (
        output valid, ok, read_value, top_return_address, frame_count,
        input  ready
    );

    modport sink (
        input  valid, ok, read_value, top_return_address, frame_count,
        output ready
    );
endinterface

// ===== hw/rtl/call_frame_stack_unit.sv =====
// ============================================================================
// call_frame_stack_unit
// Interpreter call-frame stack held in a word RAM, with APB capacity register.
// ============================================================================
// Usage:
//   req (valid/ready) carries one operation: push, pop, read or write of a
//   variable. rsp (valid/ready) returns exactly one result per request: ok,
//   read data, the top frame's return address and the frame count.
//   One request is worked on at a time; req.ready is high while the
//   controller is idle. Steps from acceptance to the result register:
//     push  : one zero/header write per cycle into the RAM, header last
//     pop   : header read, then read of the new top header; the second read
//             is skipped when the last frame goes
//     read/write at depth d : one header walked per cycle, then the access
//     failed checks : straight to the result register
//   The result sits in an output register, so the next request is taken
//   while it waits; a stalled rsp holds the controller only when a second
//   result is ready and the register is still full.
//   Reset clears the frame count and used bytes and sets the capacity to 8192
//   bytes; the word RAM is not cleared, every word is written by a push before
//   use. capacity_bytes is APB address 0; write it only while idle (unenforced).
// ============================================================================
module call_frame_stack_unit #(
    parameter int STORE_WORDS  = cfs_pkg::STORE_WORDS_DEF,
    parameter int HEADER_BYTES = cfs_pkg::HEADER_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    cfs_req_if.sink                       req,
    cfs_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfs_pkg::PADDR_W-1:0]   paddr,
    input  logic [cfs_pkg::PDATA_W-1:0]   pwdata,
    output logic [cfs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int AW          = $clog2(STORE_WORDS);
    localparam int HDR_WORDS   = (HEADER_BYTES + 7) / 8;
    localparam int STORE_BYTES = STORE_WORDS * 8;
    localparam int UB_W        = cfs_pkg::UB_W;
    localparam int TOP_W       = cfs_pkg::TOP_W;
    localparam int CNT_W       = cfs_pkg::CNT_W;
    localparam int FSZ_W       = cfs_pkg::FSZ_W;
    localparam int CAP_W       = cfs_pkg::CAP_W;
    localparam int DATA_W      = cfs_pkg::DATA_W;
    localparam int VC_W        = cfs_pkg::VC_W;
    localparam int RA_W        = cfs_pkg::RA_W;
    localparam int FC_W        = cfs_pkg::FC_W;
    localparam logic [CNT_W-1:0] HDR_CNT = CNT_W'(HDR_WORDS);

    // Control state
    cfs_pkg::state_t               state_reg;
    cfs_pkg::state_t               state_next;
    logic [CAP_W-1:0]              cap_reg;
    logic [UB_W-1:0]               used_reg;
    logic [FC_W-1:0]               frames_reg;
    logic [RA_W-1:0]               top_ret_reg;
    logic                          out_valid_reg;

    // Request and working registers
    cfs_pkg::op_t                  op_reg;
    logic [RA_W-1:0]               ret_reg;
    logic [VC_W-1:0]               vc_reg;
    logic [cfs_pkg::DEPTH_W-1:0]   depth_reg;
    logic [cfs_pkg::IDX_W-1:0]     idx_reg;
    logic [DATA_W-1:0]             wval_reg;
    logic [cfs_pkg::NB_W-1:0]      nb_reg;
    logic [CNT_W-1:0]              fill_cnt_reg;
    logic [TOP_W-1:0]              walk_top_reg;
    logic [cfs_pkg::DEPTH_W-1:0]   walk_i_reg;
    logic [AW-1:0]                 acc_addr_reg;
    logic                          ok_reg;
    logic [DATA_W-1:0]             rval_reg;
    logic                          out_ok_reg;
    logic [DATA_W-1:0]             out_rval_reg;
    logic [RA_W-1:0]               out_ret_reg;
    logic [FC_W-1:0]               out_fc_reg;

    // RAM ports
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [DATA_W-1:0]             ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [DATA_W-1:0]             ram_rdata;

    // Datapath terms
    logic [CAP_W-1:0]              cap_eff;
    logic [TOP_W-1:0]              top_w;
    logic [CNT_W-1:0]              frame_words;
    logic [FSZ_W-1:0]              push_fsize;
    logic                          push_ok;
    logic                          pop_ok;
    logic                          acc_ok;
    logic                          fill_last;
    logic [DATA_W-1:0]             hdr_word;
    logic [VC_W-1:0]               hdr_vc;
    logic [RA_W-1:0]               hdr_ret;
    logic [FSZ_W-1:0]              pop_fsize;
    logic [UB_W-1:0]               pop_used;
    logic [FC_W-1:0]               pop_frames;
    logic [CNT_W-1:0]              walk_top_x;
    logic [CNT_W-1:0]              walk_step;
    logic [CNT_W-1:0]              walk_next_top;
    logic                          walk_hit;
    logic                          walk_go;
    logic                          hit_ok;
    logic [CNT_W-1:0]              hit_addr;
    logic [DATA_W-1:0]             acc_mask;
    logic [DATA_W-1:0]             merged;
    logic                          out_free;
    logic                          cfg_wr;

    cfs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == cfs_pkg::REG_CAPACITY);
    assign prdata = (paddr[2] == cfs_pkg::REG_CAPACITY) ?
                    cfs_pkg::PDATA_W'(cap_reg) : '0;

    // Usable capacity is bounded by the store size
    assign cap_eff = ({18'b0, cap_reg} > 32'(STORE_BYTES)) ? CAP_W'(STORE_BYTES) : cap_reg;
    assign top_w   = used_reg[UB_W-1:3];

    // Push checks and header word
    assign frame_words = HDR_CNT + CNT_W'(vc_reg);
    assign push_fsize  = {frame_words, 3'b000};
    assign push_ok     = (frames_reg != cfs_pkg::FRAMES_MAX) && (used_reg <= cap_eff) &&
                         (push_fsize <= FSZ_W'(cap_eff - used_reg));
    assign fill_last   = (fill_cnt_reg == frame_words - CNT_W'(1));
    assign hdr_word    = {{(DATA_W - cfs_pkg::HDR_VC_LSB - VC_W){1'b0}}, vc_reg, ret_reg};

    // Pop checks and new top
    assign pop_ok     = (frames_reg != '0) && (used_reg >= UB_W'(8));
    assign hdr_vc     = ram_rdata[cfs_pkg::HDR_VC_LSB +: VC_W];
    assign hdr_ret    = ram_rdata[RA_W-1:0];
    assign pop_fsize  = {HDR_CNT + CNT_W'(hdr_vc), 3'b000};
    assign pop_used   = (pop_fsize <= FSZ_W'(used_reg)) ?
                        UB_W'(FSZ_W'(used_reg) - pop_fsize) : '0;
    assign pop_frames = frames_reg - FC_W'(1);

    // Variable access checks and header walk
    assign acc_ok        = (nb_reg inside {[1:8]}) && (depth_reg < frames_reg) &&
                           (CNT_W'(top_w) >= HDR_CNT);
    assign walk_top_x    = CNT_W'(walk_top_reg);
    assign walk_step     = HDR_CNT + CNT_W'(hdr_vc);
    assign walk_next_top = walk_top_x - walk_step;
    assign walk_hit      = (walk_i_reg == depth_reg);
    assign walk_go       = (walk_step <= walk_top_x) && (walk_next_top >= HDR_CNT);
    assign hit_ok        = (CNT_W'(idx_reg) < CNT_W'(hdr_vc)) && (walk_top_x >= walk_step);
    assign hit_addr      = walk_next_top + CNT_W'(idx_reg);
    assign acc_mask      = cfs_pkg::byte_mask(nb_reg);
    assign merged        = (ram_rdata & ~acc_mask) | (wval_reg & acc_mask);

    assign out_free = !out_valid_reg || rsp.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cfs_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = cfs_pkg::ST_EXEC;
                end
            end
            cfs_pkg::ST_EXEC:
            begin
                case (op_reg)
                    cfs_pkg::OP_PUSH: state_next = push_ok ? cfs_pkg::ST_FILL : cfs_pkg::ST_DONE;
                    cfs_pkg::OP_POP:  state_next = pop_ok ? cfs_pkg::ST_POP_HDR : cfs_pkg::ST_DONE;
                    default:          state_next = acc_ok ? cfs_pkg::ST_WALK : cfs_pkg::ST_DONE;
                endcase
            end
            cfs_pkg::ST_FILL:
            begin
                if (fill_last)
                begin
                    state_next = cfs_pkg::ST_DONE;
                end
            end
            cfs_pkg::ST_POP_HDR:
            begin
                state_next = (pop_frames != '0) ? cfs_pkg::ST_POP_RET : cfs_pkg::ST_DONE;
            end
            cfs_pkg::ST_POP_RET:
            begin
                state_next = cfs_pkg::ST_DONE;
            end
            cfs_pkg::ST_WALK:
            begin
                if (walk_hit)
                begin
                    state_next = hit_ok ? cfs_pkg::ST_ACCESS : cfs_pkg::ST_DONE;
                end
                else if (!walk_go)
                begin
                    state_next = cfs_pkg::ST_DONE;
                end
            end
            cfs_pkg::ST_ACCESS:
            begin
                state_next = cfs_pkg::ST_DONE;
            end
            cfs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = cfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake and RAM controls
    always_comb
    begin
        req.ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        case (state_reg)
            cfs_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            cfs_pkg::ST_EXEC:
            begin
                // top header, used by pop and by the walk
                ram_raddr = AW'(top_w - TOP_W'(1));
            end
            cfs_pkg::ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(CNT_W'(top_w) + fill_cnt_reg);
                ram_wdata = fill_last ? hdr_word : '0;
            end
            cfs_pkg::ST_POP_HDR:
            begin
                ram_raddr = AW'(pop_used[UB_W-1:3] - TOP_W'(1));
            end
            cfs_pkg::ST_WALK:
            begin
                ram_raddr = walk_hit ? AW'(hit_addr) : AW'(walk_next_top - CNT_W'(1));
            end
            cfs_pkg::ST_ACCESS:
            begin
                if (op_reg == cfs_pkg::OP_WRITE)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = acc_addr_reg;
                    ram_wdata = merged;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfs_pkg::ST_IDLE;
            cap_reg       <= cfs_pkg::CAP_RESET;
            used_reg      <= '0;
            frames_reg    <= '0;
            top_ret_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
            // Result register: filled when a result is done, freed on handshake
            if (state_reg == cfs_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                cfs_pkg::ST_FILL:
                begin
                    if (fill_last)
                    begin
                        used_reg    <= used_reg + UB_W'(push_fsize);
                        frames_reg  <= frames_reg + FC_W'(1);
                        top_ret_reg <= ret_reg;
                    end
                end
                cfs_pkg::ST_POP_HDR:
                begin
                    used_reg   <= pop_used;
                    frames_reg <= pop_frames;
                    if (pop_frames == '0)
                    begin
                        top_ret_reg <= '0;
                    end
                end
                cfs_pkg::ST_POP_RET:
                begin
                    top_ret_reg <= hdr_ret;
                end
                default:
                begin
                    used_reg <= used_reg;
                end
            endcase
        end
    end

    // Request fields and working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            cfs_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_reg    <= req.op;
                    ret_reg   <= req.return_address;
                    vc_reg    <= req.var_count;
                    depth_reg <= req.frame_depth;
                    idx_reg   <= req.var_index;
                    wval_reg  <= req.write_value;
                    nb_reg    <= req.byte_count;
                end
            end
            cfs_pkg::ST_EXEC:
            begin
                ok_reg       <= 1'b0;
                rval_reg     <= '0;
                fill_cnt_reg <= '0;
                walk_top_reg <= top_w;
                walk_i_reg   <= '0;
            end
            cfs_pkg::ST_FILL:
            begin
                fill_cnt_reg <= fill_cnt_reg + CNT_W'(1);
                if (fill_last)
                begin
                    ok_reg <= 1'b1;
                end
            end
            cfs_pkg::ST_POP_HDR:
            begin
                ok_reg <= 1'b1;
            end
            cfs_pkg::ST_WALK:
            begin
                if (walk_hit)
                begin
                    acc_addr_reg <= AW'(hit_addr);
                end
                else
                begin
                    walk_top_reg <= TOP_W'(walk_next_top);
                    walk_i_reg   <= walk_i_reg + cfs_pkg::DEPTH_W'(1);
                end
            end
            cfs_pkg::ST_ACCESS:
            begin
                ok_reg <= 1'b1;
                if (op_reg == cfs_pkg::OP_READ)
                begin
                    rval_reg <= ram_rdata & acc_mask;
                end
            end
            cfs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_ok_reg   <= ok_reg;
                    out_rval_reg <= rval_reg;
                    out_ret_reg  <= (frames_reg == '0) ? '0 : top_ret_reg;
                    out_fc_reg   <= frames_reg;
                end
            end
            default:
            begin
                ok_reg <= ok_reg;
            end
        endcase
    end

    // Response channel
    assign rsp.valid              = out_valid_reg;
    assign rsp.ok                 = out_ok_reg;
    assign rsp.read_value         = out_rval_reg;
    assign rsp.top_return_address = out_ret_reg;
    assign rsp.frame_count        = out_fc_reg;

endmodule

// ===== hw/rtl/cfs_ram.sv =====
// ============================================================================
// cfs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
module cfs_ram #(
    parameter int WIDTH = cfs_pkg::DATA_W,
    parameter int DEPTH = cfs_pkg::STORE_WORDS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
